FILE: hdl/hdlc_async_deframer_core_assert.svh
// Assertion macros for the HDLC async deframer checker.
// Expects signals named clk and rst_n in the scope of use.
`ifndef HDLC_ASYNC_DEFRAMER_CORE_ASSERT_SVH
`define HDLC_ASYNC_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define HDAD_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define HDAD_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: hdl/hdad_pkg.sv
// Shared constants, types and the CRC step for the HDLC async deframer.
// No dependencies; used by every module of the block.
`default_nettype none

package hdad_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int POS_W        = $clog2(BUFFER_DEPTH);
    localparam int ADDR_W       = POS_W + 1;
    localparam int MEM_DEPTH    = 2 * BUFFER_DEPTH;
    localparam int BYTE_W       = 8;
    localparam int LIM_W        = 7;
    localparam int LEN_W        = 6;

    localparam logic [BYTE_W-1:0] FLAG_OCTET = 8'h7E;
    localparam logic [BYTE_W-1:0] ESC_OCTET  = 8'h7D;
    localparam logic [BYTE_W-1:0] ESC_XOR    = 8'h20;
    localparam logic [15:0]       CRC_INIT   = 16'hFFFF;
    localparam logic [LIM_W-1:0]  DEPTH_LIM  = LIM_W'(BUFFER_DEPTH);

    // Buffer write from the front part
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } memwr_t;

    // One checked frame waiting for readout
    typedef struct packed {
        logic             bank;
        logic [POS_W-1:0] n;
    } desc_t;

    // Bank handed back once its last byte has been read
    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

    // One reflected CRC-16-CCITT byte step
    function automatic logic [15:0] crc_step(input logic [15:0] crc,
                                             input logic [BYTE_W-1:0] octet);
        logic [7:0] d;
        d = octet ^ crc[7:0];
        d = d ^ {d[3:0], 4'h0};
        return {d, crc[15:8]} ^ {12'h000, d[7:4]} ^ {5'h00, d, 3'b000};
    endfunction

endpackage

`default_nettype wire

FILE: hdl/hdad_front.sv
// Front part: unescapes received bytes, fills one of two frame banks, runs the CRC.
// Depends on hdad_pkg; feeds hdad_desc_q and the buffer inside hdad_back.
`default_nettype none

module hdad_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [hdad_pkg::BYTE_W-1:0]   rx_byte,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hdad_pkg::LIM_W-1:0]    cfg_data,
    output hdad_pkg::memwr_t              mem_wr,
    output logic                          desc_push,
    output hdad_pkg::desc_t               desc,
    input  hdad_pkg::rel_t                rel
);
    import hdad_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [15:0]       crc_reg, crc_next;
    logic              esc_reg, esc_next;
    logic [BYTE_W-1:0] last_reg, last_next;
    logic [BYTE_W-1:0] prev_reg, prev_next;
    logic              bank_reg, bank_next;
    logic [1:0]        busy_reg, busy_next;
    logic [LIM_W-1:0]  limit_reg;

    logic              in_fire;
    logic              is_flag;
    logic              is_esc;
    logic [BYTE_W-1:0] store_byte;
    logic              do_store;
    logic              pos_ge2;
    logic              frame_ok;
    logic [POS_W:0]    pos_inc;
    logic [LIM_W-1:0]  eff_limit;
    logic              limit_hit;

    // Classify the incoming byte
    assign full       = busy_reg[bank_reg];
    assign in_fire    = push && !full;
    assign is_flag    = (rx_byte == FLAG_OCTET);
    assign is_esc     = (rx_byte == ESC_OCTET);
    assign store_byte = esc_reg ? (rx_byte ^ ESC_XOR) : rx_byte;
    assign do_store   = in_fire && !is_flag && (esc_reg || !is_esc);
    assign pos_ge2    = (pos_reg >= POS_W'(2));
    assign frame_ok   = in_fire && is_flag && !esc_reg && pos_ge2
                        && ({last_reg, prev_reg} == crc_reg);

    // Out-of-range limits fall back to the full buffer
    assign eff_limit  = ((limit_reg == '0) || (limit_reg > DEPTH_LIM)) ? DEPTH_LIM : limit_reg;
    assign pos_inc    = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign limit_hit  = (LIM_W'(pos_inc) == eff_limit);

    // Buffer write and frame hand-off
    assign mem_wr.en   = do_store;
    assign mem_wr.addr = {bank_reg, pos_reg};
    assign mem_wr.data = store_byte;
    assign desc_push   = frame_ok;
    assign desc.bank   = bank_reg;
    assign desc.n      = pos_reg - POS_W'(2);
    assign cfg_ready   = 1'b1;

    // Next state of the receive loop
    always_comb
    begin
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        esc_next  = esc_reg;
        last_next = last_reg;
        prev_next = prev_reg;
        if (in_fire)
        begin
            if (is_flag)
            begin
                esc_next = 1'b0;
                pos_next = '0;
                crc_next = CRC_INIT;
            end
            else if (esc_reg || !is_esc)
            begin
                esc_next  = 1'b0;
                prev_next = last_reg;
                last_next = store_byte;
                if (limit_hit)
                begin
                    pos_next = '0;
                    crc_next = CRC_INIT;
                end
                else
                begin
                    pos_next = pos_inc[POS_W-1:0];
                    crc_next = pos_ge2 ? crc_step(crc_reg, prev_reg) : crc_reg;
                end
            end
            else
            begin
                esc_next = 1'b1;
            end
        end
    end

    // Track which banks are held by the readout side
    always_comb
    begin
        busy_next = busy_reg;
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (frame_ok)
        begin
            busy_next[bank_reg] = 1'b1;
        end
        bank_next = frame_ok ? !bank_reg : bank_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            crc_reg   <= CRC_INIT;
            esc_reg   <= 1'b0;
            bank_reg  <= 1'b0;
            busy_reg  <= '0;
            limit_reg <= DEPTH_LIM;
        end
        else
        begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            esc_reg  <= esc_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // Hold the last two stored bytes
    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        prev_reg <= prev_next;
    end

endmodule

`default_nettype wire

FILE: hdl/hdad_desc_q.sv
// Two-entry queue of checked-frame descriptors between front and back parts.
// Depends on hdad_pkg.
`default_nettype none

module hdad_desc_q (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hdad_pkg::desc_t push_desc,
    input  logic            pop,
    output logic            valid,
    output hdad_pkg::desc_t head
);
    import hdad_pkg::*;

    desc_t      entry_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       popping;

    assign valid   = (cnt_reg != 2'd0);
    assign head    = entry_reg[rd_reg];
    assign popping = pop && valid;

    // Advance pointers and count
    always_comb
    begin
        wr_next  = push ? !wr_reg : wr_reg;
        rd_next  = popping ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, popping};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/hdad_back.sv
// Back part: holds the two-bank frame buffer and reads frames out as results.
// Depends on hdad_pkg; takes descriptors from hdad_desc_q.
`default_nettype none

module hdad_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  hdad_pkg::memwr_t             mem_wr,
    input  logic                         desc_valid,
    input  hdad_pkg::desc_t              desc_head,
    output logic                         desc_pop,
    output hdad_pkg::rel_t               rel,
    input  logic                         pop,
    output logic                         empty,
    output logic [hdad_pkg::BYTE_W-1:0]  payload_byte,
    output logic [hdad_pkg::LEN_W-1:0]   byte_index,
    output logic [hdad_pkg::LEN_W-1:0]   payload_len,
    output logic                         has_byte,
    output logic                         last
);
    import hdad_pkg::*;

    typedef struct packed {
        logic [LEN_W-1:0] idx;
        logic [LEN_W-1:0] len;
        logic             has;
        logic             lst;
    } tok_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        tok_t              tok;
    } result_t;

    logic [BYTE_W-1:0] mem [MEM_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    tok_t              tok_reg;
    logic              pend_reg;

    logic              cur_valid_reg;
    logic              cur_bank_reg;
    logic [POS_W-1:0]  cur_n_reg;
    logic [POS_W-1:0]  k_reg;

    result_t           ob_reg [2];
    logic              ob_wr_reg;
    logic              ob_rd_reg;
    logic [1:0]        ob_cnt_reg, ob_cnt_next;

    logic              popping;
    logic [2:0]        occ;
    logic              issue;
    logic              tok_last;
    tok_t              tok_new;
    result_t           entry;
    result_t           head;

    // Issue a read only when the output buffer will have room for it
    assign popping  = pop && (ob_cnt_reg != 2'd0);
    assign occ      = 3'(ob_cnt_reg) + 3'(pend_reg) - 3'(popping);
    assign issue    = cur_valid_reg && (occ <= 3'd1);
    assign tok_last = (cur_n_reg == '0)
                      || (({1'b0, k_reg} + (POS_W+1)'(1)) == {1'b0, cur_n_reg});
    assign desc_pop = desc_valid && !cur_valid_reg;
    assign rel.valid = issue && tok_last;
    assign rel.bank  = cur_bank_reg;

    assign tok_new.idx = LEN_W'(k_reg);
    assign tok_new.len = LEN_W'(cur_n_reg);
    assign tok_new.has = (cur_n_reg != '0);
    assign tok_new.lst = tok_last;

    // Empty-frame marker carries a zero byte
    assign entry.data = tok_reg.has ? rd_data_reg : '0;
    assign entry.tok  = tok_reg;

    assign ob_cnt_next  = ob_cnt_reg + {1'b0, pend_reg} - {1'b0, popping};
    assign head         = ob_reg[ob_rd_reg];
    assign empty        = (ob_cnt_reg == 2'd0);
    assign payload_byte = head.data;
    assign byte_index   = head.tok.idx;
    assign payload_len  = head.tok.len;
    assign has_byte     = head.tok.has;
    assign last         = head.tok.lst;

    // Frame buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            mem[mem_wr.addr] <= mem_wr.data;
        end
        if (issue)
        begin
            rd_data_reg <= mem[{cur_bank_reg, k_reg}];
            tok_reg     <= tok_new;
        end
    end

    // Walk the current frame
    always_ff @(posedge clk)
    begin
        if (desc_pop)
        begin
            cur_bank_reg <= desc_head.bank;
            cur_n_reg    <= desc_head.n;
            k_reg        <= '0;
        end
        else if (issue)
        begin
            k_reg <= k_reg + POS_W'(1);
        end
    end

    // Capture read results into the output buffer
    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            ob_reg[ob_wr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            ob_wr_reg     <= 1'b0;
            ob_rd_reg     <= 1'b0;
            ob_cnt_reg    <= 2'd0;
        end
        else
        begin
            if (desc_pop)
            begin
                cur_valid_reg <= 1'b1;
            end
            else if (issue && tok_last)
            begin
                cur_valid_reg <= 1'b0;
            end
            pend_reg   <= issue;
            ob_cnt_reg <= ob_cnt_next;
            if (pend_reg)
            begin
                ob_wr_reg <= !ob_wr_reg;
            end
            if (popping)
            begin
                ob_rd_reg <= !ob_rd_reg;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/hdlc_async_deframer_core.sv
// HDLC asynchronous deframer with CRC-16-CCITT check, top level.
// Depends on hdad_pkg, hdad_front, hdad_desc_q and hdad_back.
//
// Push one received octet per cycle; the block strips flags (0x7E) and
// escapes (0x7D, next octet XOR 0x20), stores the frame and checks its
// reflected CRC-16-CCITT (init 0xFFFF, no final XOR, FCS low byte first).
// Each good frame comes out as one result per payload byte with a last mark,
// or as a single marker result with has_byte low when the payload is empty;
// bad, short and over-long frames vanish silently. Input takes one octet
// per cycle while full is low, and output gives one result per cycle within
// a frame while pop is held. Frames fill two buffer banks in turn, and full
// is high while the bank being filled is still being read out: after a
// good frame of n payload bytes closes, the next good frame may still
// close, but input after it waits until the first frame has left its
// bank. Readout of a frame starts the cycle after its closing flag when
// the back part is idle; its bank is freed once the read of its last
// byte is issued, and reads wait while the output buffer is full.
// frame_limit may be written through the cfg channel, which is always
// ready; 0 or values above 64 mean 64.
`default_nettype none

module hdlc_async_deframer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [hdad_pkg::BYTE_W-1:0]   rx_byte,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hdad_pkg::LIM_W-1:0]    cfg_data,
    input  logic                          pop,
    output logic                          empty,
    output logic [hdad_pkg::BYTE_W-1:0]   payload_byte,
    output logic [hdad_pkg::LEN_W-1:0]    byte_index,
    output logic [hdad_pkg::LEN_W-1:0]    payload_len,
    output logic                          has_byte,
    output logic                          last
);
    import hdad_pkg::*;

    memwr_t mem_wr;
    logic   desc_push;
    desc_t  desc_in;
    logic   desc_valid;
    desc_t  desc_head;
    logic   desc_pop;
    rel_t   rel;

    // Receive, unescape and check
    hdad_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .rx_byte   (rx_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .mem_wr    (mem_wr),
        .desc_push (desc_push),
        .desc      (desc_in),
        .rel       (rel)
    );

    // Hand checked frames across
    hdad_desc_q u_desc_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (desc_push),
        .push_desc (desc_in),
        .pop       (desc_pop),
        .valid     (desc_valid),
        .head      (desc_head)
    );

    // Read frames out
    hdad_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .mem_wr       (mem_wr),
        .desc_valid   (desc_valid),
        .desc_head    (desc_head),
        .desc_pop     (desc_pop),
        .rel          (rel),
        .pop          (pop),
        .empty        (empty),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .payload_len  (payload_len),
        .has_byte     (has_byte),
        .last         (last)
    );

endmodule

`default_nettype wire

FILE: hdl/hdad_checker.sv
// Port-level checker for hdlc_async_deframer_core, attached by bind.
// Depends on hdad_pkg and hdlc_async_deframer_core_assert.svh.
`default_nettype none

`include "hdlc_async_deframer_core_assert.svh"

module hdad_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pop,
    input  logic                          empty,
    input  logic [hdad_pkg::BYTE_W-1:0]   payload_byte,
    input  logic [hdad_pkg::LEN_W-1:0]    byte_index,
    input  logic [hdad_pkg::LEN_W-1:0]    payload_len,
    input  logic                          has_byte,
    input  logic                          last
);
    import hdad_pkg::*;

    // Hold a waiting result until it is taken
    `HDAD_ASSERT_NEXT(a_hold_result, (!empty && !pop), (!empty && $stable(payload_byte) && $stable(byte_index) && $stable(last)), "waiting result changed")

    // Empty-frame marker is a lone final result
    `HDAD_ASSERT_NOW(a_marker_form, (!empty && !has_byte), (last && (payload_len == '0) && (byte_index == '0) && (payload_byte == '0)), "malformed empty-frame marker")

    // Byte position stays inside the frame
    `HDAD_ASSERT_NOW(a_index_range, (!empty && has_byte), (byte_index < payload_len), "byte index beyond frame length")

    // Last mark sits exactly on the final byte
    `HDAD_ASSERT_NOW(a_last_pos, (!empty && has_byte), (last == ((7'(byte_index) + 7'd1) == 7'(payload_len))), "last mark misplaced")

endmodule

bind hdlc_async_deframer_core hdad_checker u_hdad_checker (.*);

`default_nettype wire

FILE: test/hdad_deframe_checker.sv
// Checker for the HDLC async deframer: watches the octet, config and result channels.
// Predicts delivered payload results and compares them field by field.
// Depends on hdad_pkg for widths and framing constants.
module hdad_deframe_checker
    import hdad_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [LIM_W-1:0]  cfg_data,
    input  logic              pop,
    input  logic              empty,
    input  logic [BYTE_W-1:0] payload_byte,
    input  logic [LEN_W-1:0]  byte_index,
    input  logic [LEN_W-1:0]  payload_len,
    input  logic              has_byte,
    input  logic              last,
    output int                errors,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Reflected CCITT polynomial
    localparam logic [15:0] CRC_POLY_REV = 16'h8408;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  idx;
        logic [LEN_W-1:0]  len;
        logic              has;
        logic              last;
    } frame_result_t;

    frame_result_t     due_results[$];
    logic [BYTE_W-1:0] rx_store[BUFFER_DEPTH];
    int                wr_pos;
    logic [15:0]       fcs_acc;
    logic              esc_seen;
    logic [LIM_W-1:0]  limit_reg;

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        repeat (8)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY_REV) : (r >> 1);
        end
        return r;
    endfunction

    // Out-of-range limits fall back to the full buffer
    function automatic int active_limit(input logic [LIM_W-1:0] v);
        if (v == 0 || v > BUFFER_DEPTH)
            return BUFFER_DEPTH;
        return int'(v);
    endfunction

    // Advance the receive state by one octet; queue any delivered results
    task automatic deframe_octet(input logic [BYTE_W-1:0] rx);
        logic [BYTE_W-1:0] b;
        logic [15:0]       fcs;
        frame_result_t     r;
        int                n;
        if (rx == FLAG_OCTET)
        begin
            if (esc_seen)
            begin
                // flag right after an escape clears the escape and drops the frame
                esc_seen = 1'b0;
            end
            else if (wr_pos >= 2)
            begin
                fcs = {rx_store[wr_pos-1], rx_store[wr_pos-2]};
                if (fcs == fcs_acc)
                begin
                    n = wr_pos - 2;
                    if (n == 0)
                    begin
                        // empty payload: one marker with no byte
                        r = '{data: '0, idx: '0, len: '0, has: 1'b0, last: 1'b1};
                        due_results.push_back(r);
                    end
                    else
                    begin
                        for (int k = 0; k < n; k++)
                        begin
                            r.data = rx_store[k];
                            r.idx  = LEN_W'(k);
                            r.len  = LEN_W'(n);
                            r.has  = 1'b1;
                            r.last = (k + 1 == n);
                            due_results.push_back(r);
                        end
                    end
                end
            end
            wr_pos  = 0;
            fcs_acc = CRC_INIT;
        end
        else if (!esc_seen && rx == ESC_OCTET)
        begin
            esc_seen = 1'b1;
        end
        else
        begin
            b = esc_seen ? (rx ^ ESC_XOR) : rx;
            esc_seen = 1'b0;
            rx_store[wr_pos] = b;
            // CRC trails the write position by two octets
            if (wr_pos >= 2)
                fcs_acc = crc_fold(fcs_acc, rx_store[wr_pos-2]);
            wr_pos = (wr_pos + 1) % BUFFER_DEPTH;
            // drop the frame silently once the limit is reached
            if (wr_pos == active_limit(limit_reg) % BUFFER_DEPTH)
            begin
                wr_pos  = 0;
                fcs_acc = CRC_INIT;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%02h, got 0x%02h", $time, name, want, got);
        end
    endtask

    // Compare result transfers first so a result shown in the same cycle as its octet gets flagged
    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t want;
        if (!rst_n)
        begin
            due_results.delete();
            foreach (rx_store[i])
                rx_store[i] = '0;
            wr_pos    = 0;
            fcs_acc   = CRC_INIT;
            esc_seen  = 1'b0;
            limit_reg = DEPTH_LIM;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit_reg = cfg_data;
            if (pop && !empty)
            begin
                if (due_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: expected none, got %02h/%0d/%0d/%b/%b",
                             $time, payload_byte, byte_index, payload_len, has_byte, last);
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("payload_byte", want.data, payload_byte);
                    check_field("byte_index", 8'(want.idx), 8'(byte_index));
                    check_field("payload_len", 8'(want.len), 8'(payload_len));
                    check_field("has_byte", 8'(want.has), 8'(has_byte));
                    check_field("last", 8'(want.last), 8'(last));
                end
            end
            if (push && !full)
                deframe_octet(rx_byte);
        end
        pending = due_results.size();
    end

endmodule

FILE: test/hdlc_async_deframer_core_tb.sv
// Testbench top for hdlc_async_deframer_core: clock, reset, octet and result drivers.
// Builds framed, escaped HDLC traffic under several frame limits and gives the verdict.
// Depends on hdad_pkg, the deframer RTL and hdad_deframe_checker.
module hdlc_async_deframer_core_tb;
    import hdad_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] CRC_POLY_REV   = 16'h8408;
    localparam int          NUM_PHASES     = 9;
    localparam int          PHASE_LIMIT[NUM_PHASES] = '{64, 3, 1, 2, 127, 0, 10, 64, 37};
    localparam int          PHASE_ITEMS[NUM_PHASES] = '{95, 20, 12, 12, 48, 32, 32, 56, 32};
    localparam int          HOLD_CYCLES    = 600;
    localparam int          DRAIN_CYCLES   = 16;
    localparam int          TAIL_CYCLES    = 40;
    localparam int          WATCHDOG_LIMIT = 4000;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic [BYTE_W-1:0] rx_byte;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [LIM_W-1:0]  cfg_data;
    logic              pop;
    logic              empty;
    logic [BYTE_W-1:0] payload_byte;
    logic [LEN_W-1:0]  byte_index;
    logic [LEN_W-1:0]  payload_len;
    logic              has_byte;
    logic              last;

    int                errors;
    int                pending;
    int                octets_sent;
    int                quiet_cycles;
    int                cur_limit;
    logic              tx_burst;
    logic              rx_burst;
    logic              hold_due;
    logic [BYTE_W-1:0] frame_buf[$];

    hdlc_async_deframer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .rx_byte      (rx_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .pop          (pop),
        .empty        (empty),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .payload_len  (payload_len),
        .has_byte     (has_byte),
        .last         (last)
    );

    hdad_deframe_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .rx_byte      (rx_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .pop          (pop),
        .empty        (empty),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .payload_len  (payload_len),
        .has_byte     (has_byte),
        .last         (last),
        .errors       (errors),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // End the run if no transfer of any kind happens for too long
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // FCS over the queued payload, sent low byte first
    function automatic logic [15:0] frame_fcs();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_buf[i])
        begin
            c = c ^ {8'h00, frame_buf[i]};
            repeat (8)
            begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY_REV) : (c >> 1);
            end
        end
        return c;
    endfunction

    function automatic int usable_limit(input int v);
        return (v == 0 || v > BUFFER_DEPTH) ? BUFFER_DEPTH : v;
    endfunction

    function automatic logic [BYTE_W-1:0] random_octet();
        case ($urandom_range(0, 15))
            0:       return FLAG_OCTET;
            1:       return ESC_OCTET;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one octet after a random gap; hold it until the transfer
    task automatic send_octet(input logic [BYTE_W-1:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        push    = 1'b1;
        rx_byte = b;
        do @(posedge clk); while (full);
        @(negedge clk);
        push = 1'b0;
        octets_sent++;
    endtask

    // Append FCS to frame_buf, escape as needed, close with a flag
    task automatic send_frame(input logic bad_fcs, input logic extra_escapes);
        logic [15:0]       fcs;
        logic [BYTE_W-1:0] b;
        fcs = frame_fcs();
        if (bad_fcs)
            fcs = fcs ^ (16'h0001 << $urandom_range(0, 15));
        frame_buf.push_back(fcs[7:0]);
        frame_buf.push_back(fcs[15:8]);
        foreach (frame_buf[i])
        begin
            b = frame_buf[i];
            if (b == FLAG_OCTET || b == ESC_OCTET ||
                (extra_escapes && (b ^ ESC_XOR) != FLAG_OCTET && $urandom_range(0, 15) == 0))
            begin
                send_octet(ESC_OCTET);
                send_octet(b ^ ESC_XOR);
            end
            else
            begin
                send_octet(b);
            end
        end
        send_octet(FLAG_OCTET);
    endtask

    // One random frame or burst of junk; always ends on a flag
    task automatic random_frame();
        int kind;
        int n;
        int maxn;
        int lim;
        lim      = usable_limit(cur_limit);
        maxn     = lim - 3;
        tx_burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0)
            send_octet(FLAG_OCTET);
        kind = $urandom_range(0, 99);
        frame_buf.delete();
        if (kind < 86)
        begin
            if (kind >= 80)
                n = lim - 2 + $urandom_range(0, 3);
            else if (maxn < 0)
                n = $urandom_range(0, 2);
            else if ($urandom_range(0, 15) == 0)
                n = maxn;
            else
                n = $urandom_range(0, (maxn < 8) ? maxn : 8);
            repeat (n) frame_buf.push_back(random_octet());
            send_frame(kind >= 70 && kind < 80, 1'b1);
        end
        else if (kind < 92)
        begin
            // abort: escape immediately followed by a flag
            repeat ($urandom_range(0, 4)) send_octet(random_octet());
            send_octet(ESC_OCTET);
            send_octet(FLAG_OCTET);
        end
        else
        begin
            repeat ($urandom_range(1, 6)) send_octet(random_octet());
            send_octet(FLAG_OCTET);
        end
    endtask

    // Write the frame limit once all results are out and the pipe is quiet
    task automatic program_limit(input int v);
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = LIM_W'(v);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        cur_limit = v;
    endtask

    // Result side: random stalls, bursts, and one long hold-off on request
    initial
    begin : result_sink
        int stall;
        pop      = 1'b0;
        rx_burst = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_due)
            begin
                pop = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_due = 1'b0;
            end
            if ($urandom_range(0, 19) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                pop = 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop = 1'b1;
            do @(posedge clk); while (empty);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int budget;
        rst_n       = 1'b0;
        push        = 1'b0;
        rx_byte     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        hold_due    = 1'b0;
        tx_burst    = 1'b0;
        octets_sent = 0;
        cur_limit   = PHASE_LIMIT[0];
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // flag on an empty buffer
        send_octet(FLAG_OCTET);
        // empty payload, FCS only
        frame_buf = {};
        send_frame(1'b0, 1'b0);
        frame_buf = {8'h00};
        send_frame(1'b0, 1'b0);
        // payload that needs escaping, plus all-ones
        frame_buf = {FLAG_OCTET, ESC_OCTET, 8'hFF};
        send_frame(1'b0, 1'b0);
        // escape then flag aborts the frame
        send_octet(8'h41);
        send_octet(ESC_OCTET);
        send_octet(FLAG_OCTET);
        // too short to hold an FCS
        send_octet(8'h5A);
        send_octet(FLAG_OCTET);
        // corrupted FCS
        frame_buf = {8'hA5};
        send_frame(1'b1, 1'b0);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph > 0)
                program_limit(PHASE_LIMIT[ph]);
            else
                hold_due = 1'b1;
            budget = octets_sent + PHASE_ITEMS[ph];
            while (octets_sent < budget)
                random_frame();
        end

        // drain and let the pipe settle before the verdict
        push = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
